@@ hw/rtl/ldf_pkg.sv @@
// Shared types and constants for the length-prefixed frame deframer.
package ldf_pkg;

    // Frame layout constants.
    localparam int unsigned HEADER_LEN    = 2;
    localparam int unsigned MIN_FRAME_LEN = 3;
    localparam int unsigned BYTE_SHIFT    = 8;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned KIND_W   = 2;

    // Depth of the output queue that sits between the step logic and the port.
    localparam int unsigned OUT_DEPTH = 2;

    // Kind of a result beat.
    typedef enum logic [KIND_W-1:0] {
        KIND_OPCODE = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } ldf_kind_t;

    // Receive phase within a frame.
    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_OPCODE = 2'd2,
        PH_BODY   = 2'd3
    } ldf_phase_t;

    // One result beat.
    typedef struct packed {
        ldf_kind_t             kind;
        logic [BYTE_W-1:0]     value;
        logic [LENGTH_W-1:0]   frame_length;
        logic                  frame_end;
    } ldf_result_t;

endpackage

@@ hw/rtl/length_prefix_deframer.sv @@
// A byte is held in the input register, and its result beat then waits in the result queue.
// Throughput: one byte per cycle unless in_stall; the step is a 16-bit increment and compare.
// A two-entry result queue lets input beats flow while one result waits to be taken.
// Reset: rst_n clears the frame state to await a length high byte and clears the error flag.
// After a bad length result every further byte is dropped until the next reset.
// Top level of the length-prefixed frame deframer.
module length_prefix_deframer
    import ldf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KIND_W-1:0]   kind,
    output logic [BYTE_W-1:0]   value,
    output logic [LENGTH_W-1:0] frame_length,
    output logic                frame_end
);

    logic        push_ok;
    logic        res_valid;
    ldf_result_t res;
    ldf_result_t out_data;

    // Per-byte state machine.
    ldf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .push_ok   (push_ok),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue.
    ldf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .push_ok   (push_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign value        = out_data.value;
    assign frame_length = out_data.frame_length;
    assign frame_end    = out_data.frame_end;

endmodule

@@ hw/rtl/ldf_core.sv @@
// Input register, frame state and per-byte step logic of the deframer.
module ldf_core
    import ldf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              push_ok,
    output logic              res_valid,
    output ldf_result_t       res
);

    logic                hold_valid_reg;
    logic [BYTE_W-1:0]   hold_byte_reg;
    ldf_phase_t          phase_reg, phase_next;
    logic [BYTE_W-1:0]   length_high_reg, length_high_next;
    logic [LENGTH_W-1:0] declared_length_reg, declared_length_next;
    logic [LENGTH_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic                failed_reg, failed_next;
    logic                advance;
    logic [LENGTH_W-1:0] length_word;
    logic [LENGTH_W-1:0] bytes_inc;
    logic                last_byte;

    // The held beat moves on whenever the output queue has room.
    assign advance  = hold_valid_reg && push_ok;
    assign in_stall = hold_valid_reg && !push_ok;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            hold_byte_reg <= rx_byte;
        end
    end

    // Length word and frame position for the held byte.
    assign length_word = {length_high_reg, hold_byte_reg};
    assign bytes_inc   = bytes_seen_reg + LENGTH_W'(1);
    assign last_byte   = (bytes_inc >= declared_length_reg);

    // Step of the frame state and the result it gives.
    always_comb
    begin
        phase_next           = phase_reg;
        length_high_next     = length_high_reg;
        declared_length_next = declared_length_reg;
        bytes_seen_next      = bytes_seen_reg;
        failed_next          = failed_reg;
        res_valid            = 1'b0;
        res.kind             = KIND_OPCODE;
        res.value            = hold_byte_reg;
        res.frame_length     = declared_length_reg;
        res.frame_end        = last_byte;

        if (advance && !failed_reg)
        begin
            case (phase_reg)
                PH_LEN_HI:
                begin
                    length_high_next = hold_byte_reg;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    declared_length_next = length_word;
                    if (length_word < LENGTH_W'(MIN_FRAME_LEN))
                    begin
                        // A length too short to hold an opcode poisons the stream.
                        failed_next      = 1'b1;
                        res_valid        = 1'b1;
                        res.kind         = KIND_ERROR;
                        res.value        = '0;
                        res.frame_length = length_word;
                        res.frame_end    = 1'b0;
                    end
                    else
                    begin
                        bytes_seen_next = LENGTH_W'(HEADER_LEN);
                        phase_next      = PH_OPCODE;
                    end
                end
                PH_OPCODE:
                begin
                    bytes_seen_next = bytes_inc;
                    phase_next      = last_byte ? PH_LEN_HI : PH_BODY;
                    res_valid       = 1'b1;
                    res.kind        = KIND_OPCODE;
                end
                default:
                begin
                    bytes_seen_next = bytes_inc;
                    if (last_byte)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    res_valid = 1'b1;
                    res.kind  = KIND_BODY;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_LEN_HI;
            length_high_reg     <= '0;
            declared_length_reg <= '0;
            bytes_seen_reg      <= '0;
            failed_reg          <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            length_high_reg     <= length_high_next;
            declared_length_reg <= declared_length_next;
            bytes_seen_reg      <= bytes_seen_next;
            failed_reg          <= failed_next;
        end
    end

endmodule

@@ hw/rtl/ldf_out_fifo.sv @@
// Two-entry result queue that decouples the step logic from output stalls.
module ldf_out_fifo
    import ldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ldf_result_t push_data,
    output logic        push_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output ldf_result_t out_data
);

    localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

    ldf_result_t        entry_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;

    assign push_ok   = (count_reg != CNT_W'(OUT_DEPTH));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/ldf_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module ldf_checker
    import ldf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [KIND_W-1:0]   kind,
    input logic [BYTE_W-1:0]   value,
    input logic [LENGTH_W-1:0] frame_length,
    input logic                frame_end
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // An error beat carries a short length, a zero value and no frame end.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |->
            frame_length < LENGTH_W'(MIN_FRAME_LEN) && value == '0 && !frame_end)
        else $error("malformed error beat");

    // Once the error beat has gone, the block stays silent until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_ERROR |=> !out_valid)
        else $error("result after bad length");

    // Body bytes only exist in frames long enough to have a body.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BODY |-> frame_length > LENGTH_W'(MIN_FRAME_LEN))
        else $error("body beat in a frame without a body");

    // Only the three defined kinds appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_OPCODE || kind == KIND_BODY || kind == KIND_ERROR)
        else $error("undefined result kind");

endmodule

bind length_prefix_deframer ldf_checker u_ldf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .value        (value),
    .frame_length (frame_length),
    .frame_end    (frame_end)
);

@@ tb/sv/tb_length_prefix_deframer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed frame deframer.
module tb_length_prefix_deframer;
    import ldf_pkg::*;

    // Result beats pass the input register and the result queue, so a short settle suffices.
    localparam int unsigned LATENCY     = 2;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 450;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   value;
    logic [LENGTH_W-1:0] frame_length;
    logic                frame_end;

    length_prefix_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value        (value),
        .frame_length (frame_length),
        .frame_end    (frame_end)
    );

    // Shadow copy of the deframer state, advanced once per accepted byte.
    ldf_phase_t          rx_phase;
    logic [BYTE_W-1:0]   rx_len_hi;
    logic [LENGTH_W-1:0] rx_decl_len;
    logic [LENGTH_W-1:0] rx_seen;
    logic                rx_failed;

    ldf_result_t pending_beats[$];
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    bit          in_gaps_on;
    bit          out_stalls_on;
    int unsigned stall_left;
    int unsigned flow_left;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Work out what one accepted byte should produce and queue it.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        ldf_result_t beat;
        logic        last;
        if (rx_failed)
            return;
        case (rx_phase)
            PH_LEN_HI:
            begin
                rx_len_hi = b;
                rx_phase  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                rx_decl_len = {rx_len_hi, b};
                if (rx_decl_len < LENGTH_W'(MIN_FRAME_LEN))
                begin
                    // A length too short to hold an opcode stops the block for good.
                    rx_failed         = 1'b1;
                    beat.kind         = KIND_ERROR;
                    beat.value        = '0;
                    beat.frame_length = rx_decl_len;
                    beat.frame_end    = 1'b0;
                    pending_beats     = {pending_beats, beat};
                end
                else
                begin
                    rx_seen  = LENGTH_W'(HEADER_LEN);
                    rx_phase = PH_OPCODE;
                end
            end
            default:
            begin
                rx_seen           = rx_seen + LENGTH_W'(1);
                last              = (rx_seen >= rx_decl_len);
                beat.kind         = (rx_phase == PH_OPCODE) ? KIND_OPCODE : KIND_BODY;
                beat.value        = b;
                beat.frame_length = rx_decl_len;
                beat.frame_end    = last;
                pending_beats     = {pending_beats, beat};
                rx_phase = last ? PH_LEN_HI : PH_BODY;
            end
        endcase
    endtask

    // Offer one byte, entered and left at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = in_gaps_on ? idle_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        deframe_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // A complete well-formed frame with random opcode and body.
    task automatic send_frame(input logic [LENGTH_W-1:0] len);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int unsigned i = HEADER_LEN; i < len; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Frames of the minimum length end on the opcode beat.
    task automatic test_shortest_frames();
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'hFF);
    endtask

    // Short bodies carrying the byte extremes.
    task automatic test_short_bodies();
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'h80);
    endtask

    // Random well-formed frames, mostly short and a few past 255 bytes.
    task automatic test_random_frames();
        int unsigned     r;
        logic [LENGTH_W-1:0] len;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                len = LENGTH_W'($urandom_range(3, 24));
            else if (r < 95)
                len = LENGTH_W'($urandom_range(25, 80));
            else
                len = LENGTH_W'($urandom_range(256, 400));
            send_frame(len);
        end
    endtask

    // A frame whose length uses both length bytes, run back to back with no idling.
    task automatic test_long_frame();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        send_frame(16'h0140);
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // A bad length gives one error beat, then every byte is dropped.
    task automatic test_bad_length();
        send_byte(8'h00);
        send_byte(BYTE_W'($urandom_range(0, 2)));
        repeat (20)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Output stall pattern: runs of flow broken by stalls of random length.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        flow_left  = 0;
        forever
        begin
            @(negedge clk);
            if (!out_stalls_on)
                out_stall <= 1'b0;
            else if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (flow_left != 0)
                    flow_left--;
                else
                begin
                    flow_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 30);
                    stall_left = idle_len();
                end
            end
        end
    end

    // Compare every result beat taken with the oldest expected one.
    always @(posedge clk)
    begin
        ldf_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d value %0h", kind, value);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    mismatches++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %0h, actual %0h", want.value, value);
                    mismatches++;
                end
                if (frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, actual %0d",
                           want.frame_length, frame_length);
                    mismatches++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Timeout guard.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        mismatches    = 0;
        bytes_sent    = 0;
        rx_phase      = PH_LEN_HI;
        rx_len_hi     = '0;
        rx_decl_len   = '0;
        rx_seen       = '0;
        rx_failed     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_shortest_frames();
        test_short_bodies();
        test_random_frames();
        test_long_frame();
        test_bad_length();

        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatches == 0 && pending_beats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_core.sv
hw/rtl/ldf_out_fifo.sv
hw/rtl/length_prefix_deframer.sv
hw/rtl/ldf_checker.sv
tb/sv/tb_length_prefix_deframer.sv
